[src/mmtc_pkg.sv]
// ----------------------------------------------------------------------------
// mmtc_pkg
// shared types and constants for the min/max tint colour map block
// ----------------------------------------------------------------------------
package mmtc_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int Q_BITS      = 8;
	localparam int NUM_W       = SAMPLE_BITS + Q_BITS;
	localparam int CNT_W       = $clog2(Q_BITS);
	localparam int IDX_W       = 2;

	localparam logic [7:0]             FULL     = 8'd255;
	localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic {
		OP_SCAN = 1'b0,
		OP_MAP  = 1'b1
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_TINT_RED   = 2'd0,
		REG_TINT_GREEN = 2'd1,
		REG_TINT_BLUE  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic scan;
		logic capture;
		logic prep;
		logic mul;
		logic step;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic flat;
		logic last;
	} status_t;

endpackage

[src/minmax_tint_colormap_top.sv]
// ----------------------------------------------------------------------------
// minmax_tint_colormap_top
// min/max normalisation of a sample stream onto a white-to-tint gradient
// ----------------------------------------------------------------------------
// usage: stream the samples twice. scan requests (operation 0) track the
// lowest and highest sample, first_sample restarts both. map requests
// (operation 1) each give one BGR pixel, white at the minimum and the tint at
// the maximum; a flat range gives white with flat_range set.
// channels: input request (in_valid/in_ready), result (out_valid/out_ready),
// register writes (cfg_valid/cfg_ready, never stalled): 0 red, 1 green,
// 2 blue tint; other indexes are dropped.
// timing: scans run one per cycle while no map request is in progress. a
// map request runs capture, range prep, the scaling multiply, 8 restoring
// division steps (one quotient bit per step in each of three channel
// dividers) and the output load before the next request is taken. the
// result shows in the cycle after the load; a flat range skips the division.
// stall: a waiting result sits in the output register; the next map request
// is taken in, and held at the output load until the result is taken.
// reset: tints, minimum and maximum clear to zero, no result pending.
// ----------------------------------------------------------------------------
module minmax_tint_colormap_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic                        first_sample,
	input  logic signed [31:0]          sample,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  blue,
	output logic [7:0]                  green,
	output logic [7:0]                  red,
	output logic                        flat_range,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mmtc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [7:0]                  cfg_data
);

	mmtc_pkg::cmd_t    cmd;
	mmtc_pkg::status_t status;

	assign cfg_ready = 1'b1;

	mmtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mmtc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.first_sample (first_sample),
		.sample       (sample),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.flat_range   (flat_range)
	);

endmodule

[src/mmtc_lane.sv]
// ----------------------------------------------------------------------------
// mmtc_lane
// one colour channel: scaled offset then restoring division, one bit a cycle
// ----------------------------------------------------------------------------
module mmtc_lane (
	input  logic                            clk,
	input  mmtc_pkg::cmd_t                  cmd,
	input  logic [mmtc_pkg::SAMPLE_BITS-1:0] diff,
	input  logic [mmtc_pkg::SAMPLE_BITS-1:0] range,
	input  logic [7:0]                      tint,
	output logic [mmtc_pkg::Q_BITS-1:0]     quot,
	output logic                            rem_nz
);

	logic [7:0]                   span;
	logic [mmtc_pkg::NUM_W-1:0]   prod;
	logic [mmtc_pkg::NUM_W-1:0]   rem_q;
	logic [mmtc_pkg::NUM_W-1:0]   div_q;
	logic [mmtc_pkg::NUM_W:0]     trial;
	logic [mmtc_pkg::Q_BITS-1:0]  quot_q;

	assign span  = mmtc_pkg::FULL - tint;
	assign prod  = mmtc_pkg::NUM_W'(diff) * mmtc_pkg::NUM_W'(span);
	assign trial = {1'b0, rem_q} - {1'b0, div_q};

	// quotient never exceeds span since diff <= range, so eight bits suffice
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rem_q  <= prod;
			div_q  <= mmtc_pkg::NUM_W'({range, {(mmtc_pkg::Q_BITS-1){1'b0}}});
			quot_q <= '0;
		end else if (cmd.step) begin
			if (!trial[mmtc_pkg::NUM_W]) begin
				rem_q <= trial[mmtc_pkg::NUM_W-1:0];
			end
			quot_q <= {quot_q[mmtc_pkg::Q_BITS-2:0], ~trial[mmtc_pkg::NUM_W]};
			div_q  <= div_q >> 1;
		end
	end

	assign quot   = quot_q;
	assign rem_nz = |rem_q;

endmodule

[src/mmtc_dp.sv]
// ----------------------------------------------------------------------------
// mmtc_dp
// datapath: tint registers, min/max tracking, range prep, three lanes, output
// ----------------------------------------------------------------------------
module mmtc_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mmtc_pkg::cmd_t               cmd,
	output mmtc_pkg::status_t            status,
	input  logic                         cfg_valid,
	input  logic [mmtc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [7:0]                   cfg_data,
	input  logic                         first_sample,
	input  logic [31:0]                  sample,
	output logic [7:0]                   blue,
	output logic [7:0]                   green,
	output logic [7:0]                   red,
	output logic                         flat_range
);

	localparam int SB = mmtc_pkg::SAMPLE_BITS;

	logic [7:0]    tint_red_q, tint_green_q, tint_blue_q;
	logic [SB-1:0] low_q, high_q;
	logic [SB-1:0] raw, key_in, key_lo, key_hi;
	logic [SB-1:0] key_s1;
	logic [SB-1:0] range_q, diff_q;
	logic [SB-1:0] range_c, offs_c, diff_c;
	logic          flat_q;
	logic [mmtc_pkg::CNT_W-1:0] cnt_q;
	logic [mmtc_pkg::Q_BITS-1:0] q_r, q_g, q_b;
	logic          nz_r, nz_g, nz_b;
	logic [7:0]    blue_q, green_q, red_q;
	logic          flat_out_q;

	assign raw    = sample[SB-1:0];
	// offset binary keys: unsigned order matches signed order
	assign key_in = raw ^ mmtc_pkg::SIGN_BIT;
	assign key_lo = low_q ^ mmtc_pkg::SIGN_BIT;
	assign key_hi = high_q ^ mmtc_pkg::SIGN_BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_red_q   <= '0;
			tint_green_q <= '0;
			tint_blue_q  <= '0;
		end else if (cfg_valid) begin
			unique case (mmtc_pkg::reg_idx_t'(cfg_index))
				mmtc_pkg::REG_TINT_RED:   tint_red_q   <= cfg_data;
				mmtc_pkg::REG_TINT_GREEN: tint_green_q <= cfg_data;
				mmtc_pkg::REG_TINT_BLUE:  tint_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
		end else if (cmd.scan) begin
			if (first_sample) begin
				low_q  <= raw;
				high_q <= raw;
			end else begin
				if (key_in < key_lo) low_q  <= raw;
				if (key_in > key_hi) high_q <= raw;
			end
		end
	end

	// range and saturated offset from the captured key
	always_comb begin
		range_c = (key_hi >= key_lo) ? key_hi - key_lo : '0;
		offs_c  = key_s1 - key_lo;
		if (key_s1 <= key_lo) begin
			diff_c = '0;
		end else if (offs_c >= range_c) begin
			diff_c = range_c;
		end else begin
			diff_c = offs_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_s1 <= key_in;
		end
		if (cmd.prep) begin
			range_q <= range_c;
			diff_q  <= diff_c;
			flat_q  <= (range_c == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.mul) begin
			cnt_q <= mmtc_pkg::CNT_W'(mmtc_pkg::Q_BITS - 1);
		end else if (cmd.step) begin
			cnt_q <= cnt_q - mmtc_pkg::CNT_W'(1);
		end
	end

	assign status.flat = flat_q;
	assign status.last = (cnt_q == '0);

	mmtc_lane u_lane_r (
		.clk    (clk),
		.cmd    (cmd),
		.diff   (diff_q),
		.range  (range_q),
		.tint   (tint_red_q),
		.quot   (q_r),
		.rem_nz (nz_r)
	);

	mmtc_lane u_lane_g (
		.clk    (clk),
		.cmd    (cmd),
		.diff   (diff_q),
		.range  (range_q),
		.tint   (tint_green_q),
		.quot   (q_g),
		.rem_nz (nz_g)
	);

	mmtc_lane u_lane_b (
		.clk    (clk),
		.cmd    (cmd),
		.diff   (diff_q),
		.range  (range_q),
		.tint   (tint_blue_q),
		.quot   (q_b),
		.rem_nz (nz_b)
	);

	// ceiling: round the quotient up when a remainder is left
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			flat_out_q <= flat_q;
			if (flat_q) begin
				red_q   <= mmtc_pkg::FULL;
				green_q <= mmtc_pkg::FULL;
				blue_q  <= mmtc_pkg::FULL;
			end else begin
				red_q   <= mmtc_pkg::FULL - (q_r + {7'd0, nz_r});
				green_q <= mmtc_pkg::FULL - (q_g + {7'd0, nz_g});
				blue_q  <= mmtc_pkg::FULL - (q_b + {7'd0, nz_b});
			end
		end
	end

	assign blue       = blue_q;
	assign green      = green_q;
	assign red        = red_q;
	assign flat_range = flat_out_q;

endmodule

[src/mmtc_ctrl.sv]
// ----------------------------------------------------------------------------
// mmtc_ctrl
// controller: sequences capture, prep, multiply, division steps and output
// ----------------------------------------------------------------------------
module mmtc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	output logic               out_valid,
	input  logic               out_ready,
	input  mmtc_pkg::status_t  status,
	output mmtc_pkg::cmd_t     cmd
);

	mmtc_pkg::state_t state_q, state_d;
	logic             accept;
	logic             out_free;
	logic             out_valid_q;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmtc_pkg::ST_IDLE: begin
				if (accept && mmtc_pkg::op_t'(operation) == mmtc_pkg::OP_MAP) begin
					state_d = mmtc_pkg::ST_PREP;
				end
			end
			mmtc_pkg::ST_PREP: state_d = mmtc_pkg::ST_MUL;
			mmtc_pkg::ST_MUL: begin
				state_d = status.flat ? mmtc_pkg::ST_OUT : mmtc_pkg::ST_DIV;
			end
			mmtc_pkg::ST_DIV: begin
				if (status.last) state_d = mmtc_pkg::ST_OUT;
			end
			mmtc_pkg::ST_OUT: begin
				if (out_free) state_d = mmtc_pkg::ST_IDLE;
			end
			default: state_d = mmtc_pkg::ST_IDLE;
		endcase
	end

	// ready is always high in idle, so a request there is taken on valid alone
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			mmtc_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.scan    = in_valid && mmtc_pkg::op_t'(operation) == mmtc_pkg::OP_SCAN;
				cmd.capture = in_valid && mmtc_pkg::op_t'(operation) == mmtc_pkg::OP_MAP;
			end
			mmtc_pkg::ST_PREP: cmd.prep = 1'b1;
			mmtc_pkg::ST_MUL:  cmd.mul  = !status.flat;
			mmtc_pkg::ST_DIV:  cmd.step = 1'b1;
			mmtc_pkg::ST_OUT:  cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mmtc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[src/mmtc_checker.sv]
// ----------------------------------------------------------------------------
// mmtc_checker
// port-level checks on the colour map block, bound to the top level
// ----------------------------------------------------------------------------
module mmtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        operation,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  blue,
	input logic [7:0]  green,
	input logic [7:0]  red,
	input logic        flat_range
);

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({blue, green, red, flat_range}))
		else $error("result changed while stalled");

	// flat range always reads as white
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flat_range |-> blue == 8'd255 && green == 8'd255 && red == 8'd255)
		else $error("flat range result not white");

	// a map request keeps the block busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == mmtc_pkg::OP_MAP |=> !in_ready)
		else $error("map request not sequenced");

	// a scan request never raises a result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == mmtc_pkg::OP_SCAN |=> !$rose(out_valid))
		else $error("scan request produced a result");

endmodule

bind minmax_tint_colormap_top mmtc_checker u_mmtc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.operation  (operation),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.blue       (blue),
	.green      (green),
	.red        (red),
	.flat_range (flat_range)
);
